@@ rtl/vlmi_pkg.sv @@
`timescale 1ns / 1ps

package vlmi_pkg;

  // Fixed-point format of velocities, accelerations and times.
  localparam int FRAC_BITS  = 16;
  localparam int WORD_WIDTH = 32;
  // Position carries the full integer range of a word plus the fraction.
  localparam int LOC_WIDTH  = WORD_WIDTH + FRAC_BITS;

  // Shared multiplier: one extra operand bit holds a velocity sum.
  localparam int MUL_W  = WORD_WIDTH + 1;
  localparam int PROD_W = 2 * MUL_W;

  // Ramp-time divider: numerator is a velocity difference scaled by 2^FRAC_BITS.
  localparam int NUM_W     = WORD_WIDTH + 1 + FRAC_BITS;
  localparam int QUO_W     = WORD_WIDTH - 1;
  localparam int DIV_CNT_W = $clog2(WORD_WIDTH);

  localparam logic signed [WORD_WIDTH-1:0] VMIN_RST = '0;
  localparam logic signed [WORD_WIDTH-1:0] VMAX_RST = WORD_WIDTH'(10 << FRAC_BITS);
  localparam logic signed [WORD_WIDTH-1:0] AMIN_RST = WORD_WIDTH'(-(2 << FRAC_BITS));
  localparam logic signed [WORD_WIDTH-1:0] AMAX_RST = WORD_WIDTH'(2 << FRAC_BITS);

  typedef enum logic [1:0] {
    CFG_VMIN = 2'd0,
    CFG_VMAX = 2'd1,
    CFG_AMIN = 2'd2,
    CFG_AMAX = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AT,
    S_VSUM,
    S_VRND,
    S_CLASS,
    S_PREP,
    S_DIV,
    S_DWAIT,
    S_SEG,
    S_SRND,
    S_CRU,
    S_CRND,
    S_CADD,
    S_FIN,
    S_LOC,
    S_OUT
  } st_e;

  typedef struct packed {
    logic signed [WORD_WIDTH-1:0] accel_command;
    logic signed [WORD_WIDTH-1:0] step_time;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_WIDTH-1:0] distance;
    logic signed [WORD_WIDTH-1:0] new_speed;
    logic signed [LOC_WIDTH-1:0]  new_location;
    logic                         step_error;
  } out_word_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

  // Inverted range: a value below lo gives lo, any other value gives hi.
  function automatic logic signed [WORD_WIDTH-1:0] clamp_word(
    input logic signed [WORD_WIDTH-1:0] x,
    input logic signed [WORD_WIDTH-1:0] lo,
    input logic signed [WORD_WIDTH-1:0] hi
  );
    logic signed [WORD_WIDTH-1:0] r;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

  // Divide by 2^s, round to nearest with ties away from zero. For a negative
  // value the bias is one less, which gives the same result in one add.
  function automatic logic signed [PROD_W-1:0] rnd_shift(
    input logic signed [PROD_W-1:0] x,
    input int unsigned              s
  );
    logic signed [PROD_W-1:0] bias;
    bias = $signed((PROD_W'(1) << (s - 1)) - PROD_W'(x[PROD_W-1]));
    return (x + bias) >>> s;
  endfunction

endpackage

@@ rtl/velocity_limited_motion_integrator.sv @@
`timescale 1ns / 1ps

// Integrates one motion step per input word: the acceleration command is
// clamped to the configured range, the velocity is advanced and limited to
// the configured velocity range, and the step's distance, the new velocity
// and the saturated 48-bit position come back as one output word. All values
// are signed fixed point with 16 fraction bits. One word is processed at a
// time and the input is stalled meanwhile. A step that hits a velocity limit
// can spend most of its time in the one-bit-per-cycle divider that finds the
// ramp time (31 quotient bits), and a step with a negative time goes
// straight to the output stage. A single registered multiplier serves
// all products. Configuration writes are taken in any cycle and are meant to
// happen only while no step is in flight.
module velocity_limited_motion_integrator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  vlmi_pkg::in_word_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output vlmi_pkg::out_word_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  vlmi_pkg::cfg_idx_e            cfg_index_i,
  input  logic [vlmi_pkg::WORD_WIDTH-1:0] cfg_data_i
);
  import vlmi_pkg::*;

  localparam int W = WORD_WIDTH;

  st_e state_q, state_d;

  logic signed [W-1:0] vmin_q, vmax_q, amin_q, amax_q;
  logic signed [W-1:0] speed_q;
  logic signed [LOC_WIDTH-1:0] loc_q;

  logic signed [W-1:0]      a_q, t_q, vnew_q, dsat_q;
  logic                     err_q, over_q, under_q;
  logic signed [PROD_W-1:0] acc_q, vt_q, dist_q, cru_q;
  logic signed [MUL_W-1:0]  sum_q, diff_q;
  logic [QUO_W-1:0]         d_q, cru_d_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     div_start;
  div_stat_t                div_stat;
  logic [QUO_W-1:0]         quo;
  logic [NUM_W-1:0]         div_num;
  logic [W-1:0]             div_den;
  logic [MUL_W-1:0]         diff_mag;

  logic                     in_acc, out_load, out_valid_q;
  out_word_t                out_q;

  logic signed [PROD_W-1:0] speed_ext, vmax_ext, vmin_ext;
  logic signed [W-1:0]      lim, seg_q_val;
  logic                     ramp_pos;
  logic [QUO_W-1:0]         t1;
  logic signed [LOC_WIDTH:0] loc_sum;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmin_q <= VMIN_RST;
      vmax_q <= VMAX_RST;
      amin_q <= AMIN_RST;
      amax_q <= AMAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_VMIN: vmin_q <= $signed(cfg_data_i);
        CFG_VMAX: vmax_q <= $signed(cfg_data_i);
        CFG_AMIN: amin_q <= $signed(cfg_data_i);
        CFG_AMAX: amax_q <= $signed(cfg_data_i);
        default:  vmin_q <= vmin_q;
      endcase
    end
  end

  assign speed_ext = $signed({{(PROD_W-W){speed_q[W-1]}}, speed_q});
  assign vmax_ext  = $signed({{(PROD_W-W){vmax_q[W-1]}}, vmax_q});
  assign vmin_ext  = $signed({{(PROD_W-W){vmin_q[W-1]}}, vmin_q});

  assign lim       = over_q ? vmax_q : vmin_q;
  assign seg_q_val = (over_q || under_q) ? lim : vt_q[W-1:0];

  // The ramp time is positive only when the gap to the limit and the
  // acceleration point the same way; otherwise it clamps to zero.
  assign ramp_pos = (diff_q != '0) && (a_q != '0) && (diff_q[W] == a_q[W-1]);
  assign diff_mag = diff_q[W] ? MUL_W'(-diff_q) : MUL_W'(diff_q);
  assign div_num  = {diff_mag, {FRAC_BITS{1'b0}}};
  assign div_den  = a_q[W-1] ? W'(-a_q) : W'(a_q);

  assign t1 = div_stat.sat ? t_q[QUO_W-1:0]
            : ((quo < t_q[QUO_W-1:0]) ? quo : t_q[QUO_W-1:0]);

  assign loc_sum = $signed({loc_q[LOC_WIDTH-1], loc_q})
                 + $signed({{(LOC_WIDTH+1-W){dsat_q[W-1]}}, dsat_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = in_data_i.step_time[W-1] ? S_OUT : S_AT;
        end
      end
      S_AT: begin
        mul_a   = $signed({a_q[W-1], a_q});
        mul_b   = $signed({t_q[W-1], t_q});
        state_d = S_VSUM;
      end
      S_VSUM:  state_d = S_VRND;
      S_VRND:  state_d = S_CLASS;
      S_CLASS: state_d = S_PREP;
      S_PREP:  state_d = (over_q || under_q) ? S_DIV : S_SEG;
      S_DIV: begin
        div_start = ramp_pos;
        state_d   = ramp_pos ? S_DWAIT : S_SEG;
      end
      S_DWAIT: begin
        if (div_stat.done) begin
          state_d = S_SEG;
        end
      end
      S_SEG: begin
        mul_a   = sum_q;
        mul_b   = $signed({2'b00, d_q});
        state_d = S_SRND;
      end
      S_SRND:  state_d = over_q ? S_CRU : S_FIN;
      S_CRU: begin
        mul_a   = $signed({vmax_q[W-1], vmax_q});
        mul_b   = $signed({2'b00, cru_d_q});
        state_d = S_CRND;
      end
      S_CRND:  state_d = S_CADD;
      S_CADD:  state_d = S_FIN;
      S_FIN:   state_d = S_LOC;
      S_LOC:   state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  vlmi_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  vlmi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          a_q   <= clamp_word(in_data_i.accel_command, amin_q, amax_q);
          t_q   <= in_data_i.step_time;
          err_q <= in_data_i.step_time[W-1];
        end
      end
      S_VSUM:  acc_q <= prod + (speed_ext <<< FRAC_BITS);
      S_VRND:  vt_q  <= rnd_shift(acc_q, FRAC_BITS);
      S_CLASS: begin
        over_q  <= vt_q > vmax_ext;
        under_q <= !(vt_q > vmax_ext) && (vt_q < vmin_ext);
      end
      S_PREP: begin
        sum_q  <= $signed({speed_q[W-1], speed_q}) + $signed({seg_q_val[W-1], seg_q_val});
        diff_q <= $signed({lim[W-1], lim}) - $signed({speed_q[W-1], speed_q});
        vnew_q <= seg_q_val;
        d_q    <= t_q[QUO_W-1:0];
      end
      S_DIV: begin
        if (!ramp_pos) begin
          d_q <= '0;
        end
      end
      S_DWAIT: begin
        if (div_stat.done) begin
          d_q <= t1;
        end
      end
      S_SEG:  cru_d_q <= t_q[QUO_W-1:0] - d_q;
      S_SRND: dist_q  <= rnd_shift(prod, FRAC_BITS + 1);
      S_CRND: cru_q   <= rnd_shift(prod, FRAC_BITS);
      S_CADD: dist_q  <= dist_q + cru_q;
      S_FIN: begin
        if ((&dist_q[PROD_W-1:W-1]) || !(|dist_q[PROD_W-1:W-1])) begin
          dsat_q <= dist_q[W-1:0];
        end else begin
          dsat_q <= {dist_q[PROD_W-1], {(W-1){~dist_q[PROD_W-1]}}};
        end
        vnew_q <= clamp_word(vnew_q, vmin_q, vmax_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
      loc_q   <= '0;
    end else if (state_q == S_LOC) begin
      speed_q <= vnew_q;
      if (loc_sum[LOC_WIDTH] == loc_sum[LOC_WIDTH-1]) begin
        loc_q <= loc_sum[LOC_WIDTH-1:0];
      end else begin
        loc_q <= {loc_sum[LOC_WIDTH], {(LOC_WIDTH-1){~loc_sum[LOC_WIDTH]}}};
      end
    end
  end

  // The output word sits in its own register so the next step can start
  // while the result waits downstream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.distance     <= err_q ? '0 : dsat_q;
      out_q.new_speed    <= speed_q;
      out_q.new_location <= loc_q;
      out_q.step_error   <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/vlmi_mul.sv @@
`timescale 1ns / 1ps

module vlmi_mul (
  input  logic                                  clk_i,
  input  logic signed [vlmi_pkg::MUL_W-1:0]     a_i,
  input  logic signed [vlmi_pkg::MUL_W-1:0]     b_i,
  output logic signed [vlmi_pkg::PROD_W-1:0]    prod_o
);
  import vlmi_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/vlmi_div.sv @@
`timescale 1ns / 1ps

module vlmi_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [vlmi_pkg::NUM_W-1:0]        num_i,
  input  logic [vlmi_pkg::WORD_WIDTH-1:0]   den_i,
  output vlmi_pkg::div_stat_t               stat_o,
  output logic [vlmi_pkg::QUO_W-1:0]        quo_o
);
  import vlmi_pkg::*;

  localparam int HI_W = NUM_W - QUO_W;

  logic [HI_W-1:0]       n_hi;
  logic                  too_big;
  logic [WORD_WIDTH:0]   trial;
  logic                  ge;
  logic [WORD_WIDTH-1:0] rem_d, rem_q;
  logic [WORD_WIDTH-1:0] den_q;
  logic [QUO_W-1:0]      sh_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  run_q, done_q, sat_q;

  // A quotient that needs more than QUO_W bits exceeds any legal step time.
  assign n_hi    = num_i[NUM_W-1:QUO_W];
  assign too_big = NUM_W'(n_hi) >= NUM_W'(den_i);

  assign trial = {rem_q, sh_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? WORD_WIDTH'(trial - {1'b0, den_q}) : trial[WORD_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      sat_q  <= too_big;
      run_q  <= !too_big;
      done_q <= too_big;
      cnt_q  <= DIV_CNT_W'(QUO_W);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // The low dividend bits shift out at the top while quotient bits enter below.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= WORD_WIDTH'(n_hi);
      sh_q  <= num_i[QUO_W-1:0];
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[QUO_W-2:0], ge};
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.sat  = sat_q;
  assign quo_o       = sh_q;

endmodule

@@ bench/tb_velocity_limited_motion_integrator.sv @@
`timescale 1ns / 1ps

module tb_velocity_limited_motion_integrator;
  import vlmi_pkg::*;

  localparam int     ONE         = 1 << FRAC_BITS;
  localparam longint WORD_HI     = (longint'(1) <<< (WORD_WIDTH - 1)) - 1;
  localparam longint WORD_LO     = -WORD_HI - 1;
  localparam longint LOC_HI      = (longint'(1) <<< (LOC_WIDTH - 1)) - 1;
  localparam longint LOC_LO      = -LOC_HI - 1;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     RANDOM_ITEMS_PER_PHASE = 250;
  localparam int     RANDOM_PHASES = 5;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  cfg_idx_e              cfg_index_i = CFG_VMIN;
  logic [WORD_WIDTH-1:0] cfg_data_i  = '0;

  // Model state: the limit registers, velocity and position as the block should hold them.
  logic signed [WORD_WIDTH-1:0] limit_reg [4];
  logic signed [WORD_WIDTH-1:0] motion_speed;
  logic signed [LOC_WIDTH-1:0]  motion_location;
  out_word_t                    expected_motion [$];

  int idle_pct       = 36;
  int stall_pct      = 36;
  int hold_cycles    = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  velocity_limited_motion_integrator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Motion predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
    if (x < lo) begin
      return lo;
    end
    if (x > hi) begin
      return hi;
    end
    return x;
  endfunction

  // Divide by 2^s with round to nearest, ties away from zero.
  function automatic longint round_half_away(input longint x, input int s);
    longint unsigned mag;
    mag = (x < 0) ? longint'(-x) : longint'(x);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (x < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic longint ramp_distance(input longint p, input longint q, input longint d);
    return round_half_away((p + q) * d, FRAC_BITS + 1);
  endfunction

  function automatic longint time_to_limit(input longint v, input longint lim,
                                           input longint a, input longint t);
    longint r;
    if (a == 0) begin
      return 0;
    end
    r = ((lim - v) <<< FRAC_BITS) / a;
    return clamp_to(r, 0, t);
  endfunction

  function automatic out_word_t predict_motion(input in_word_t w);
    longint    vel_lo, vel_hi, acc_lo, acc_hi;
    longint    a, t, v, vt, vnew, step_dist, t1, loc;
    out_word_t r;
    vel_lo = limit_reg[CFG_VMIN];
    vel_hi = limit_reg[CFG_VMAX];
    acc_lo = limit_reg[CFG_AMIN];
    acc_hi = limit_reg[CFG_AMAX];
    a = w.accel_command;
    t = w.step_time;
    v = motion_speed;
    loc = motion_location;
    if (t < 0) begin
      r.distance     = '0;
      r.new_speed    = motion_speed;
      r.new_location = motion_location;
      r.step_error   = 1'b1;
      return r;
    end
    a = clamp_to(a, acc_lo, acc_hi);
    vt = round_half_away((v <<< FRAC_BITS) + a * t, FRAC_BITS);
    if (vt > vel_hi) begin
      // Ramp up to the ceiling, then cruise there for what is left of the step.
      t1 = time_to_limit(v, vel_hi, a, t);
      step_dist = ramp_distance(v, vel_hi, t1)
                + round_half_away(vel_hi * (t - t1), FRAC_BITS);
      vnew = vel_hi;
    end else if (vt < vel_lo) begin
      t1 = time_to_limit(v, vel_lo, a, t);
      step_dist = ramp_distance(v, vel_lo, t1);
      vnew = vel_lo;
    end else begin
      step_dist = ramp_distance(v, vt, t);
      vnew = vt;
    end
    step_dist = clamp_to(step_dist, WORD_LO, WORD_HI);
    motion_speed = WORD_WIDTH'(clamp_to(vnew, vel_lo, vel_hi));
    motion_location = LOC_WIDTH'(clamp_to(loc + step_dist, LOC_LO, LOC_HI));
    r.distance     = WORD_WIDTH'(step_dist);
    r.new_speed    = motion_speed;
    r.new_location = motion_location;
    r.step_error   = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string field, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
               field, cycle_count, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_motion.size() == 0) begin
        note_mismatch("unexpected word, distance", 0, out_data_o.distance);
      end else begin
        want = expected_motion.pop_front();
        if (out_data_o.distance !== want.distance) begin
          note_mismatch("distance", want.distance, out_data_o.distance);
        end
        if (out_data_o.new_speed !== want.new_speed) begin
          note_mismatch("new_speed", want.new_speed, out_data_o.new_speed);
        end
        if (out_data_o.new_location !== want.new_location) begin
          note_mismatch("new_location", want.new_location, out_data_o.new_location);
        end
        if (out_data_o.step_error !== want.step_error) begin
          note_mismatch("step_error", want.step_error, out_data_o.step_error);
        end
      end
    end
  end

  // A hold-off overrides the random stalls until it has counted down.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i = 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; all of them start and end at a falling edge.
  // ---------------------------------------------------------------------------

  task automatic send_step(input in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      in_data_i  = {$urandom, $urandom};
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = w;
    do @(posedge clk_i); while (in_stall_o);
    expected_motion.push_back(predict_motion(w));
    @(negedge clk_i);
  endtask

  task automatic settle_block();
    in_valid_i = 1'b0;
    while (expected_motion.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_limit(input cfg_idx_e idx, input logic signed [WORD_WIDTH-1:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_reg[idx] = value;
    @(negedge clk_i);
  endtask

  task automatic set_limits(input logic signed [WORD_WIDTH-1:0] vel_lo, vel_hi, acc_lo, acc_hi);
    settle_block();
    write_limit(CFG_VMIN, vel_lo);
    write_limit(CFG_VMAX, vel_hi);
    write_limit(CFG_AMIN, acc_lo);
    write_limit(CFG_AMAX, acc_hi);
    cfg_valid_i = 1'b0;
  endtask

  task automatic step(input longint accel, input longint dt);
    in_word_t w;
    w.accel_command = WORD_WIDTH'(accel);
    w.step_time     = WORD_WIDTH'(dt);
    send_step(w);
  endtask

  // Mostly moderate values, with full-range words and the extremes mixed in.
  function automatic logic signed [WORD_WIDTH-1:0] pick_value(input int unsigned span);
    int unsigned sel;
    longint      v;
    sel = $urandom_range(99);
    if (sel < 10) begin
      return $urandom;
    end
    if (sel < 18) begin
      case ($urandom_range(4))
        0:       return WORD_WIDTH'(WORD_LO);
        1:       return WORD_WIDTH'(WORD_HI);
        2:       return 0;
        3:       return 1;
        default: return -1;
      endcase
    end
    v = $urandom_range(0, span);
    if ($urandom_range(1)) begin
      v = -v;
    end
    return WORD_WIDTH'(v);
  endfunction

  function automatic in_word_t random_step();
    in_word_t    w;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) begin
      w = {$urandom, $urandom};
    end else begin
      w.accel_command = pick_value(5 * ONE);
      if (sel < 14) begin
        w.step_time = WORD_WIDTH'(-longint'($urandom_range(1, WORD_HI))
                                  - longint'($urandom_range(1)));
      end else if (sel < 19) begin
        w.step_time = $urandom_range(0, WORD_HI);
      end else begin
        w.step_time = $urandom_range(0, 3 * ONE);
      end
    end
    return w;
  endfunction

  task automatic random_limits();
    int unsigned sel;
    int          vel_lo, vel_hi, acc_lo, acc_hi;
    sel = $urandom_range(99);
    if (sel < 70) begin
      vel_lo = -int'($urandom_range(0, 15 * ONE));
      vel_hi = vel_lo + int'($urandom_range(ONE, 30 * ONE));
      acc_lo = -int'($urandom_range(ONE / 2, 8 * ONE));
      acc_hi = int'($urandom_range(ONE / 2, 8 * ONE));
    end else if (sel < 85) begin
      vel_lo = int'(WORD_LO);
      vel_hi = int'(WORD_HI);
      acc_lo = int'(WORD_LO);
      acc_hi = int'(WORD_HI);
    end else begin
      // Fully random, so ranges come out inverted about half the time.
      vel_lo = $urandom;
      vel_hi = $urandom;
      acc_lo = $urandom;
      acc_hi = $urandom;
    end
    set_limits(vel_lo, vel_hi, acc_lo, acc_hi);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_reset_limits();
    step(2 * ONE, ONE);                  // stays inside the velocity range
    step(WORD_HI, 2 * ONE);              // command clamped to the upper limit
    step(2 * ONE, 4 * ONE);              // ramp to the ceiling, then cruise
    step(0, ONE);                        // cruise at the ceiling
    step(WORD_LO, 8 * ONE);              // ramp down to the floor and stop
    step(0, 0);
    step(ONE, -ONE);                     // negative step time
    step(ONE, WORD_LO);
    step(3 * ONE / 2, WORD_HI);          // distance saturates
    step(-98305, 43691);                 // odd fractions to exercise rounding
  endtask

  task automatic test_limit_cases();
    set_limits(WORD_WIDTH'(WORD_LO), WORD_WIDTH'(WORD_HI),
               WORD_WIDTH'(WORD_LO), WORD_WIDTH'(WORD_HI));
    step(WORD_HI, WORD_HI);
    step(WORD_LO, WORD_HI);
    step(1, 1);
    // Speed now sits far below the default floor: the ramp outlasts the step.
    set_limits(VMIN_RST, VMAX_RST, AMIN_RST, AMAX_RST);
    step(2 * ONE, 3 * ONE);
    step(2 * ONE, 4 * ONE);
    // Ceiling dropped below the current speed with no acceleration.
    set_limits(-ONE, ONE, AMIN_RST, AMAX_RST);
    step(0, ONE);
    // Speeding up while already above the ceiling: negative ramp time.
    set_limits(-ONE, ONE / 2, AMIN_RST, AMAX_RST);
    step(ONE, ONE);
    // Inverted ranges: a value below the low bound takes the low bound, any other the high bound.
    set_limits(5 * ONE, -5 * ONE, ONE, -ONE);
    step(0, ONE);
    step(-3 * ONE, 2 * ONE);
  endtask

  task automatic test_output_backpressure();
    set_limits(VMIN_RST, VMAX_RST, AMIN_RST, AMAX_RST);
    idle_pct = 0;
    @(posedge clk_i);
    hold_cycles = 400;
    @(negedge clk_i);
    repeat (12) begin
      send_step(random_step());
    end
    idle_pct = 36;
  endtask

  task automatic test_random_steps();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        set_limits(VMIN_RST, VMAX_RST, AMIN_RST, AMAX_RST);
      end else begin
        random_limits();
      end
      // One phase runs with neither side idling.
      idle_pct  = (phase == 2) ? 0 : 36;
      stall_pct = (phase == 2) ? 0 : 36;
      repeat (RANDOM_ITEMS_PER_PHASE) begin
        send_step(random_step());
      end
    end
    idle_pct  = 36;
    stall_pct = 36;
  endtask

  initial begin
    limit_reg[CFG_VMIN] = VMIN_RST;
    limit_reg[CFG_VMAX] = VMAX_RST;
    limit_reg[CFG_AMIN] = AMIN_RST;
    limit_reg[CFG_AMAX] = AMAX_RST;
    motion_speed    = '0;
    motion_location = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_limits();
    test_limit_cases();
    test_output_backpressure();
    test_random_steps();

    settle_block();
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
